### rtl/core/lpht_pkg.sv
package lpht_pkg;

    localparam int KEY_W       = 64;
    localparam int REF_IN_W    = 16;
    localparam int SLOT_OUT_W  = 8;
    localparam int COUNT_OUT_W = 9;
    localparam int HOME_SHIFT  = 3;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic {
        ADDR_POS  = 1'b0,
        ADDR_HOLE = 1'b1
    } t_addr_sel;

    typedef enum logic [1:0] {
        WD_NEW  = 2'd0,
        WD_MOVE = 2'd1,
        WD_FREE = 2'd2
    } t_wd_sel;

    // controller to datapath
    typedef struct packed {
        logic      latch_req;
        logic      hash_start;
        logic      hash_from_ram;
        logic      pos_home;
        logic      pos_next;
        logic      pos_zero;
        logic      n_zero;
        logic      n_inc;
        logic      ram_re;
        logic      ram_we;
        t_addr_sel addr_sel;
        t_wd_sel   wd_sel;
        logic      res_init;
        logic      status_load;
        t_status   status_val;
        logic      insert_commit;
        logic      found_commit;
        logic      move_commit;
        logic      count_clear;
        logic      out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op_code;
        logic       full;
        logic       hash_done;
        logic       used;
        logic       match;
        logic       gap_empty;
        logic       keep;
        logic       n_last;
        logic       pos_last;
        logic       out_free;
    } t_stat;

endpackage

### rtl/core/lpht_ram.sv
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/lpht_home.sv
module lpht_home
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [KEY_W-1:0]               i_key,
    output logic                           o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_home
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    if ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0) begin : g_mask
        // power of two: home is a bit field of the key
        logic             r_done;
        logic [IDX_W-1:0] r_home;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
            if (i_start) begin
                r_home <= i_key[HOME_SHIFT +: IDX_W];
            end
        end

        assign o_done = r_done;
        assign o_home = r_home;
    end else begin : g_serial
        // restoring remainder, four key bits per cycle, msb first
        localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(TABLE_DEPTH);

        logic             r_busy;
        logic             r_done;
        logic [3:0]       r_cnt;
        logic [KEY_W-1:0] r_shift;
        logic [IDX_W-1:0] r_rem;
        logic [IDX_W-1:0] n_rem;
        logic [IDX_W:0]   trial;
        logic [IDX_W-1:0] rem;

        always_comb begin
            rem   = r_rem;
            trial = '0;
            for (int b = 0; b < 4; b++) begin
                trial = {rem, r_shift[KEY_W-1-b]};
                if (trial >= DEPTH_C) begin
                    trial = trial - DEPTH_C;
                end
                rem = trial[IDX_W-1:0];
            end
            n_rem = rem;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_done <= 1'b0;
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                end else if (r_busy) begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
            if (i_start) begin
                r_shift <= {{HOME_SHIFT{1'b0}}, i_key[KEY_W-1:HOME_SHIFT]};
                r_rem   <= '0;
            end else if (r_busy) begin
                r_shift <= {r_shift[KEY_W-5:0], 4'b0000};
                r_rem   <= n_rem;
            end
        end

        assign o_done = r_done;
        assign o_home = r_rem;
    end

endmodule

### rtl/core/lpht_datapath.sv
module lpht_datapath
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int REF_WIDTH   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [1:0]             i_op,
    input  logic [KEY_W-1:0]       i_key,
    input  logic [REF_IN_W-1:0]    i_ref,
    input  logic                   i_m_ready,
    output logic                   o_m_valid,
    output logic [1:0]             o_status,
    output logic [SLOT_OUT_W-1:0]  o_slot,
    output logic [COUNT_OUT_W-1:0] o_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = 1 + KEY_W + REF_WIDTH;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_DEPTH);

    // request
    logic [1:0]           r_op;
    logic [KEY_W-1:0]     r_key;
    logic [REF_WIDTH-1:0] r_ref;
    logic [31:0]          ref_ext;

    // probe state
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_hole;
    logic [IDX_W-1:0] r_orig;
    logic             r_moved;
    logic [IDX_W-1:0] r_n;
    logic [IDX_W-1:0] pos_inc;
    logic [CNT_W-1:0] r_count;

    // result
    t_status          r_res_status;
    logic [IDX_W-1:0] r_res_slot;
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [SLOT_OUT_W-1:0]  r_out_slot;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic [31:0]      slot_ext;
    logic [31:0]      count_ext;

    // memory and home unit
    logic [IDX_W-1:0]     ram_addr;
    logic [ENT_W-1:0]     ram_wdata;
    logic [ENT_W-1:0]     ram_rdata;
    logic                 rd_used;
    logic [KEY_W-1:0]     rd_key;
    logic [REF_WIDTH-1:0] rd_ref;
    logic [KEY_W-1:0]     hash_key;
    logic                 hash_done;
    logic [IDX_W-1:0]     home;

    assign ref_ext = 32'(i_ref);
    assign pos_inc = (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;

    assign rd_used = ram_rdata[ENT_W-1];
    assign rd_key  = ram_rdata[REF_WIDTH +: KEY_W];
    assign rd_ref  = ram_rdata[REF_WIDTH-1:0];

    assign ram_addr = (i_cmd.addr_sel == ADDR_HOLE) ? r_hole : r_pos;

    always_comb begin
        case (i_cmd.wd_sel)
            WD_NEW:  ram_wdata = {1'b1, r_key, r_ref};
            WD_MOVE: ram_wdata = {1'b1, rd_key, rd_ref};
            default: ram_wdata = '0;
        endcase
    end

    assign hash_key = i_cmd.hash_from_ram ? rd_key : r_key;

    lpht_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_re    (i_cmd.ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    lpht_home #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.hash_start),
        .i_key   (hash_key),
        .o_done  (hash_done),
        .o_home  (home)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pos_zero) begin
                r_pos <= '0;
            end else if (i_cmd.pos_home) begin
                r_pos <= home;
            end else if (i_cmd.pos_next) begin
                r_pos <= pos_inc;
            end

            if (i_cmd.count_clear) begin
                r_count <= '0;
            end else if (i_cmd.insert_commit) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.found_commit && r_count != '0) begin
                r_count <= r_count - 1'b1;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign slot_ext  = 32'(r_res_slot);
    assign count_ext = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_ref <= ref_ext[REF_WIDTH-1:0];
        end

        if (i_cmd.n_zero) begin
            r_n <= '0;
        end else if (i_cmd.n_inc) begin
            r_n <= r_n + 1'b1;
        end

        if (i_cmd.found_commit) begin
            r_orig  <= r_pos;
            r_hole  <= r_pos;
            r_moved <= 1'b0;
        end else if (i_cmd.move_commit) begin
            r_hole  <= r_pos;
            r_moved <= 1'b1;
        end

        if (i_cmd.status_load) begin
            r_res_status <= i_cmd.status_val;
        end else if (i_cmd.res_init) begin
            r_res_status <= ST_DONE;
        end
        if (i_cmd.res_init) begin
            r_res_slot <= '0;
        end else if (i_cmd.insert_commit || i_cmd.found_commit) begin
            r_res_slot <= r_pos;
        end

        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= slot_ext[SLOT_OUT_W-1:0];
            r_out_count  <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    always_comb begin
        o_stat.op_code   = r_op;
        o_stat.full      = (r_count == FULL_CNT);
        o_stat.hash_done = hash_done;
        o_stat.used      = rd_used;
        o_stat.match     = (rd_key == r_key) && (rd_ref == r_ref);
        // the slot being freed still shows as used until the final write
        o_stat.gap_empty = !rd_used || ((r_pos == r_orig) && !r_moved);
        // entry stays when its home lies cyclically in (hole, pos]
        o_stat.keep      = ((r_hole < home) && (home <= r_pos)) ||
                           ((r_pos < r_hole) && (r_hole < home)) ||
                           ((home <= r_pos) && (r_pos < r_hole));
        o_stat.n_last    = (r_n == LAST_IDX);
        o_stat.pos_last  = (r_pos == LAST_IDX);
        o_stat.out_free  = !r_out_valid || i_m_ready;
    end

    assign o_m_valid = r_out_valid;
    assign o_status  = r_out_status;
    assign o_slot    = r_out_slot;
    assign o_count   = r_out_count;

endmodule

### rtl/core/lpht_ctrl.sv
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_s_ready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_HOME,
        S_READ,
        S_CHECK,
        S_GAP_READ,
        S_GAP_CHECK,
        S_GAP_HOME,
        S_GAP_END,
        S_CLEAR,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   r_clr_result;
    logic   n_clr_result;
    t_cmd   cmd;

    always_comb begin
        cmd          = '0;
        n_state      = r_state;
        n_clr_result = r_clr_result;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid && r_ready) begin
                    cmd.latch_req = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.res_init = 1'b1;
                case (i_stat.op_code)
                    OP_INSERT: begin
                        if (i_stat.full) begin
                            cmd.status_load = 1'b1;
                            cmd.status_val  = ST_FULL;
                            n_state         = S_RESULT;
                        end else begin
                            cmd.hash_start = 1'b1;
                            n_state        = S_HOME;
                        end
                    end
                    OP_REMOVE: begin
                        cmd.hash_start = 1'b1;
                        n_state        = S_HOME;
                    end
                    OP_CLEAR: begin
                        cmd.pos_zero    = 1'b1;
                        cmd.count_clear = 1'b1;
                        n_clr_result    = 1'b1;
                        n_state         = S_CLEAR;
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_HOME: begin
                if (i_stat.hash_done) begin
                    cmd.pos_home = 1'b1;
                    cmd.n_zero   = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                cmd.ram_re   = 1'b1;
                cmd.addr_sel = ADDR_POS;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.op_code == OP_INSERT) begin
                    if (!i_stat.used) begin
                        cmd.ram_we        = 1'b1;
                        cmd.addr_sel      = ADDR_POS;
                        cmd.wd_sel        = WD_NEW;
                        cmd.insert_commit = 1'b1;
                        n_state           = S_RESULT;
                    end else if (i_stat.n_last) begin
                        cmd.status_load = 1'b1;
                        cmd.status_val  = ST_FULL;
                        n_state         = S_RESULT;
                    end else begin
                        cmd.n_inc    = 1'b1;
                        cmd.pos_next = 1'b1;
                        n_state      = S_READ;
                    end
                end else begin
                    if (!i_stat.used) begin
                        cmd.status_load = 1'b1;
                        cmd.status_val  = ST_NOT_FOUND;
                        n_state         = S_RESULT;
                    end else if (i_stat.match) begin
                        cmd.found_commit = 1'b1;
                        cmd.n_zero       = 1'b1;
                        cmd.pos_next     = 1'b1;
                        n_state          = S_GAP_READ;
                    end else if (i_stat.n_last) begin
                        cmd.status_load = 1'b1;
                        cmd.status_val  = ST_NOT_FOUND;
                        n_state         = S_RESULT;
                    end else begin
                        cmd.n_inc    = 1'b1;
                        cmd.pos_next = 1'b1;
                        n_state      = S_READ;
                    end
                end
            end
            S_GAP_READ: begin
                cmd.ram_re   = 1'b1;
                cmd.addr_sel = ADDR_POS;
                n_state      = S_GAP_CHECK;
            end
            S_GAP_CHECK: begin
                if (i_stat.gap_empty) begin
                    n_state = S_GAP_END;
                end else begin
                    cmd.hash_start    = 1'b1;
                    cmd.hash_from_ram = 1'b1;
                    n_state           = S_GAP_HOME;
                end
            end
            S_GAP_HOME: begin
                if (i_stat.hash_done) begin
                    if (!i_stat.keep) begin
                        cmd.ram_we      = 1'b1;
                        cmd.addr_sel    = ADDR_HOLE;
                        cmd.wd_sel      = WD_MOVE;
                        cmd.move_commit = 1'b1;
                    end
                    if (i_stat.n_last) begin
                        n_state = S_GAP_END;
                    end else begin
                        cmd.n_inc    = 1'b1;
                        cmd.pos_next = 1'b1;
                        n_state      = S_GAP_READ;
                    end
                end
            end
            S_GAP_END: begin
                cmd.ram_we   = 1'b1;
                cmd.addr_sel = ADDR_HOLE;
                cmd.wd_sel   = WD_FREE;
                n_state      = S_RESULT;
            end
            S_CLEAR: begin
                cmd.ram_we   = 1'b1;
                cmd.addr_sel = ADDR_POS;
                cmd.wd_sel   = WD_FREE;
                cmd.pos_next = 1'b1;
                if (i_stat.pos_last) begin
                    n_state = r_clr_result ? S_RESULT : S_IDLE;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_ready      <= 1'b0;
            r_clr_result <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ready      <= (n_state == S_IDLE);
            r_clr_result <= n_clr_result;
        end
    end

    assign o_cmd     = cmd;
    assign o_s_ready = r_ready;

endmodule

### rtl/core/linear_probe_hash_table_unit.sv
// one request at a time; an insert probes slot by slot (read, then check), and a remove
// also walks the run after the match to close the gap (read, check, home slot); the home-slot
// unit is slower for a non-power-of-two depth. Pacing is set by the single-port table memory
// and the shared home-slot unit; a clear sweeps the table, writing every slot in turn
// after reset the same sweep runs with s_axis_tready low
// the result register lets the next request enter while a result waits on m_axis_tready
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int REF_WIDTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // key [63:0], descriptor_ref [79:64]
    input  logic [1:0]  s_axis_tuser,  // operation [1:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // status [1:0], slot_index [9:2],
                                       // entry_count [18:10], zero [23:19]
);

    t_cmd  cmd;
    t_stat stat;

    logic [1:0]             res_status;
    logic [SLOT_OUT_W-1:0]  res_slot;
    logic [COUNT_OUT_W-1:0] res_count;

    // sequencer: probe walk, gap closing and clearing sweep
    lpht_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_s_ready (s_axis_tready)
    );

    // table memory, home-slot unit, pointers, entry count and result register
    lpht_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .REF_WIDTH   (REF_WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_op      (s_axis_tuser),
        .i_key     (s_axis_tdata[KEY_W-1:0]),
        .i_ref     (s_axis_tdata[KEY_W +: REF_IN_W]),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_status  (res_status),
        .o_slot    (res_slot),
        .o_count   (res_count)
    );

    // pack result fields, lowest first, padded to whole bytes
    assign m_axis_tdata = {5'b00000, res_count, res_slot, res_status};

endmodule

### tb/tb.sv
module tb;
    import lpht_pkg::*;

    localparam int DEPTH       = 256;
    localparam int REF_W       = 16;
    localparam int HOLD_CYCLES = 500;
    // the encoding left over by the three operations, which the block must ignore
    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    // one expected result, in the field order of the result tdata
    typedef struct packed {
        t_status          status;
        logic [7:0]       slot;
        logic [8:0]       count;
    } t_outcome;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [REF_W-1:0] dref;
    } t_pair;

    // mirror of the table contents; predicts each result as its request is accepted
    class probe_table_scoreboard;
        logic [KEY_W-1:0] key_at [DEPTH];
        logic [REF_W-1:0] ref_at [DEPTH];
        bit               used_at[DEPTH];
        int unsigned      live_total;
        int unsigned      peak_total;
        t_outcome         awaited[$];
        int unsigned      failures;
        int unsigned      checked;
        int unsigned      n_stored, n_full, n_removed, n_missed, n_clears, n_ignored;

        function new();
            foreach (used_at[i]) used_at[i] = 1'b0;
            live_total = 0;
            peak_total = 0;
            failures   = 0;
            checked    = 0;
            n_stored   = 0;
            n_full     = 0;
            n_removed  = 0;
            n_missed   = 0;
            n_clears   = 0;
            n_ignored  = 0;
        endfunction

        function int unsigned home_slot(logic [KEY_W-1:0] k);
            return int'((k >> HOME_SHIFT) % DEPTH);
        endfunction

        // backward shift: pull later run members into the hole unless their home
        // slot lies cyclically in (hole, pos]
        function void shift_back(int unsigned hole);
            int unsigned pos;
            int unsigned h;
            pos = hole;
            used_at[hole] = 1'b0;
            repeat (DEPTH) begin
                pos = (pos + 1) % DEPTH;
                if (!used_at[pos]) return;
                h = home_slot(key_at[pos]);
                if ((hole < h && h <= pos) || (pos < hole && hole < h) ||
                    (h <= pos && pos < hole))
                    continue;
                key_at[hole]  = key_at[pos];
                ref_at[hole]  = ref_at[pos];
                used_at[hole] = 1'b1;
                used_at[pos]  = 1'b0;
                hole = pos;
            end
        endfunction

        function void note_request(logic [1:0] op, logic [KEY_W-1:0] k,
                                   logic [REF_W-1:0] r);
            t_outcome    o;
            int unsigned s;
            int unsigned n;
            o.status = ST_DONE;
            o.slot   = '0;
            s = home_slot(k);
            case (op)
                OP_INSERT: begin
                    o.status = ST_FULL;
                    for (n = 0; n < DEPTH; n++) begin
                        if (!used_at[s]) begin
                            key_at[s]  = k;
                            ref_at[s]  = r;
                            used_at[s] = 1'b1;
                            live_total++;
                            o.status = ST_DONE;
                            o.slot   = s[7:0];
                            break;
                        end
                        s = (s + 1) % DEPTH;
                    end
                    if (o.status == ST_DONE) n_stored++;
                    else n_full++;
                end
                OP_REMOVE: begin
                    o.status = ST_NOT_FOUND;
                    for (n = 0; n < DEPTH; n++) begin
                        if (!used_at[s]) break;
                        if (key_at[s] == k && ref_at[s] == r) begin
                            shift_back(s);
                            if (live_total > 0) live_total--;
                            o.status = ST_DONE;
                            o.slot   = s[7:0];
                            break;
                        end
                        s = (s + 1) % DEPTH;
                    end
                    if (o.status == ST_DONE) n_removed++;
                    else n_missed++;
                end
                OP_CLEAR: begin
                    foreach (used_at[i]) used_at[i] = 1'b0;
                    live_total = 0;
                    n_clears++;
                end
                default: n_ignored++;
            endcase
            if (live_total > peak_total) peak_total = live_total;
            o.count = live_total[8:0];
            awaited.push_back(o);
        endfunction

        function void check_result(logic [23:0] data);
            t_outcome want;
            if (awaited.size() == 0) begin
                $error("result %h arrived with no request outstanding", data);
                failures++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (data[1:0] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, data[1:0]);
                failures++;
            end
            if (data[9:2] !== want.slot) begin
                $error("slot_index: expected %0d, got %0d", want.slot, data[9:2]);
                failures++;
            end
            if (data[18:10] !== want.count) begin
                $error("entry_count: expected %0d, got %0d", want.count, data[18:10]);
                failures++;
            end
            if (data[23:19] !== 5'd0) begin
                $error("padding: expected 0, got %0d", data[23:19]);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // key [63:0], descriptor_ref [79:64]
    logic [1:0]  s_axis_tuser;   // operation [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // status [1:0], slot_index [9:2], entry_count [18:10]

    probe_table_scoreboard sb;
    t_pair       live_pairs[$];     // pairs the table should hold, duplicates included
    int unsigned requests_sent;
    int unsigned cluster_base;
    bit          tx_steady;
    bit          rx_hold_req;

    linear_probe_hash_table_unit #(
        .TABLE_DEPTH (DEPTH),
        .REF_WIDTH   (REF_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // safety net against a hung handshake
    initial begin
        #24_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // offer one request after a random gap and hold it until the block takes it;
    // called at a rising edge, returns at the edge where the request was accepted
    task automatic send_request(logic [1:0] op, logic [KEY_W-1:0] k, logic [REF_W-1:0] r);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, k};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, k, r);
        requests_sent++;
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
    endtask

    function automatic int unsigned pick_home();
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, DEPTH - 1);
        return (cluster_base + $urandom_range(0, 7)) % DEPTH;
    endfunction

    // random key whose home slot is forced, upper and lower bits free
    function automatic logic [KEY_W-1:0] key_at_home(int unsigned home);
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        k[HOME_SHIFT +: 8] = home[7:0];
        return k;
    endfunction

    function automatic bit is_live(logic [KEY_W-1:0] k, logic [REF_W-1:0] r);
        foreach (live_pairs[i])
            if (live_pairs[i].key == k && live_pairs[i].dref == r) return 1'b1;
        return 1'b0;
    endfunction

    task automatic insert_pair(logic [KEY_W-1:0] k, logic [REF_W-1:0] r);
        t_pair p;
        bit    room;
        p.key  = k;
        p.dref = r;
        room   = sb.live_total < DEPTH;
        send_request(OP_INSERT, k, r);
        if (room) live_pairs.push_back(p);
    endtask

    task automatic remove_pair(logic [KEY_W-1:0] k, logic [REF_W-1:0] r);
        int idx;
        idx = -1;
        foreach (live_pairs[i])
            if (idx < 0 && live_pairs[i].key == k && live_pairs[i].dref == r) idx = i;
        if (idx >= 0) live_pairs.delete(idx);
        send_request(OP_REMOVE, k, r);
    endtask

    task automatic clear_table();
        live_pairs.delete();
        send_request(OP_CLEAR, {$urandom, $urandom}, 16'($urandom));
    endtask

    // remove of a pair that is not stored: either a fresh key or a stored key
    // with a different handle
    task automatic remove_absent();
        logic [KEY_W-1:0] k;
        logic [REF_W-1:0] r;
        int unsigned      idx;
        do begin
            if (live_pairs.size() > 0 && $urandom_range(0, 1) == 0) begin
                idx = $urandom_range(0, live_pairs.size() - 1);
                k = live_pairs[idx].key;
                r = live_pairs[idx].dref ^ 16'($urandom_range(1, 65535));
            end else begin
                k = key_at_home(pick_home());
                r = 16'($urandom);
            end
        end while (is_live(k, r));
        send_request(OP_REMOVE, k, r);
    endtask

    task automatic remove_random_live();
        int unsigned idx;
        t_pair       p;
        idx = $urandom_range(0, live_pairs.size() - 1);
        p   = live_pairs[idx];
        remove_pair(p.key, p.dref);
    endtask

    // mixed traffic; removes win more often once the fill passes the target
    task automatic run_mixed(int unsigned n, int unsigned target);
        int unsigned r;
        int unsigned remove_odds;
        repeat (n) begin
            if ($urandom_range(0, 29) == 0)
                cluster_base = ($urandom_range(0, 3) == 0) ? $urandom_range(248, 255)
                                                          : $urandom_range(0, DEPTH - 1);
            r = $urandom_range(0, 99);
            remove_odds = (sb.live_total > target) ? 65 : 35;
            if (r < 1) begin
                clear_table();
            end else if (r < 2) begin
                send_request(OP_UNDEFINED, {$urandom, $urandom}, 16'($urandom));
            end else if (r < 10) begin
                remove_absent();
            end else if (live_pairs.size() > 0 && r < remove_odds) begin
                remove_random_live();
            end else begin
                insert_pair(key_at_home(pick_home()), 16'($urandom));
            end
        end
    endtask

    // result side: random stalls per result, calm stretches, one long hold-off
    initial begin : result_sink
        int unsigned rx_wait;
        bit          rx_steady;
        rx_wait   = 0;
        rx_steady = 1'b0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
                rx_wait = rx_steady ? 0 : $urandom_range(0, 18);
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_wait     = HOLD_CYCLES;
            end
            if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [KEY_W-1:0] k;
        sb = new();
        requests_sent = 0;
        cluster_base  = 0;
        tx_steady     = 1'b0;
        rx_hold_req   = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_INSERT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, collisions wrapping past the last slot,
        // duplicates, wrong handle, misses, ignored opcode, clear
        insert_pair('0, '0);
        insert_pair('1, '1);
        insert_pair(64'h8000_0000_0000_07F8, 16'h8001);  // home is the last slot, wraps
        insert_pair('1, '1);                             // duplicate pair
        remove_pair('1, 16'h1234);                       // key stored, handle wrong
        remove_pair('1, '1);                             // gap closes across the wrap
        remove_pair(64'd5, '0);                          // not stored; the probe stops at the slot the shift freed
        remove_pair('0, '0);
        send_request(OP_UNDEFINED, 64'hDEAD_BEEF_0BAD_F00D, 16'hA5A5);
        k = key_at_home(10);
        insert_pair(k, 16'h0001);
        insert_pair(key_at_home(10), 16'h0002);
        insert_pair(key_at_home(11), 16'h0003);
        insert_pair(key_at_home(10), 16'h0004);
        remove_pair(k, 16'h0001);                        // run slides back by one
        remove_random_live();
        clear_table();
        remove_pair(64'h0123_4567_89AB_CDEF, 16'h7777);  // empty table
        insert_pair(64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
        insert_pair(64'h5555_5555_5555_5555, 16'hAAAA);
        remove_pair(64'h5555_5555_5555_5555, 16'hAAAA);
        drain_results();

        cluster_base = 250;
        run_mixed(300, 128);

        // receiver holds off while the sender keeps offering, so the block backs up
        rx_hold_req = 1'b1;
        run_mixed(60, 128);
        drain_results();

        // fill every slot, bounce off the full table, probe it end to end
        clear_table();
        while (sb.live_total < DEPTH) insert_pair(key_at_home(pick_home()), 16'($urandom));
        repeat (4) insert_pair(key_at_home(pick_home()), 16'($urandom));
        repeat (2) remove_absent();
        repeat (10) begin
            remove_random_live();
            insert_pair(key_at_home(pick_home()), 16'($urandom));
        end
        drain_results();

        clear_table();
        run_mixed(160, 200);

        drain_results();
        repeat (1400) @(posedge i_clk);

        if (sb.awaited.size() != 0) begin
            $error("%0d results never arrived", sb.awaited.size());
            sb.failures++;
        end
        $display("covered %0d requests: %0d stored, %0d refused as full, %0d removed,",
                 requests_sent, sb.n_stored, sb.n_full, sb.n_removed);
        $display("  %0d removes unmatched, %0d clears, %0d ignored, peak fill %0d of %0d",
                 sb.n_missed, sb.n_clears, sb.n_ignored, sb.peak_total, DEPTH);
        if (sb.failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/lpht_pkg.sv
rtl/core/lpht_ram.sv
rtl/core/lpht_home.sv
rtl/core/lpht_datapath.sv
rtl/core/lpht_ctrl.sv
rtl/core/linear_probe_hash_table_unit.sv
tb/tb.sv
